// ===== rtl/core/maze_backtracker_generator_core_assert.svh =====
// Assertion helpers for the maze carver core.
// Both forms sample on clk and are disabled while arst_n is low.
`ifndef MAZE_BACKTRACKER_GENERATOR_CORE_ASSERT_SVH
`define MAZE_BACKTRACKER_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define MBG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MBG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mbg_pkg.sv =====
`timescale 1ns / 1ps

package mbg_pkg;

	typedef logic [1:0] opcode_t;
	typedef logic [2:0] event_t;
	typedef logic [1:0] dir_t;
	typedef logic [3:0] wall_t;

	localparam opcode_t OP_START = 2'd0;
	localparam opcode_t OP_STEP  = 2'd1;
	localparam opcode_t OP_READ  = 2'd2;

	localparam event_t EV_STARTED     = 3'd0;
	localparam event_t EV_CARVED      = 3'd1;
	localparam event_t EV_BACKTRACKED = 3'd2;
	localparam event_t EV_FINISHED    = 3'd3;
	localparam event_t EV_READ        = 3'd4;

	localparam dir_t DIR_NORTH = 2'd0;
	localparam dir_t DIR_SOUTH = 2'd1;
	localparam dir_t DIR_EAST  = 2'd2;
	localparam dir_t DIR_WEST  = 2'd3;

	localparam wall_t MASK_N      = 4'b0001;
	localparam wall_t MASK_E      = 4'b0010;
	localparam wall_t MASK_S      = 4'b0100;
	localparam wall_t MASK_W      = 4'b1000;
	localparam wall_t MASK_CLOSED = 4'b1111;

	// neighbor probe order: west, east, north, south
	localparam dir_t PROBE_DIR [4] = '{DIR_WEST, DIR_EAST, DIR_NORTH, DIR_SOUTH};
	localparam logic [1:0] PROBE_LAST = 2'd3;

	// wall on the moving cell's side
	function automatic wall_t wall_of(input dir_t d);
		wall_t w;
		unique case (d)
			DIR_NORTH: w = MASK_N;
			DIR_SOUTH: w = MASK_S;
			DIR_EAST:  w = MASK_E;
			DIR_WEST:  w = MASK_W;
		endcase
		return w;
	endfunction

	// wall on the entered cell's side
	function automatic wall_t wall_opposite(input dir_t d);
		wall_t w;
		unique case (d)
			DIR_NORTH: w = MASK_S;
			DIR_SOUTH: w = MASK_N;
			DIR_EAST:  w = MASK_W;
			DIR_WEST:  w = MASK_E;
		endcase
		return w;
	endfunction

	// 16-bit value mod 3: base-4 digit sum (4 == 1 mod 3), then fold
	function automatic logic [1:0] mod3(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

endpackage

// ===== rtl/core/mbg_nbr.sv =====
`timescale 1ns / 1ps

// Shared neighbor unit: one step from the current cell, grid bound check, border check.
module mbg_nbr #(
	parameter int GRID_ROWS = 16,
	parameter int GRID_COLS = 16,
	localparam int RW = $clog2(GRID_ROWS),
	localparam int CW = $clog2(GRID_COLS)
) (
	input  logic [RW-1:0]     pos_row,
	input  logic [CW-1:0]     pos_col,
	input  mbg_pkg::dir_t     dir,
	output logic [RW-1:0]     nbr_row,
	output logic [CW-1:0]     nbr_col,
	output logic              in_grid,
	output logic              border
);

	localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);

	always_comb begin
		nbr_row = pos_row;
		nbr_col = pos_col;
		in_grid = 1'b0;
		unique case (dir)
			mbg_pkg::DIR_NORTH: begin
				nbr_row = pos_row - RW'(1);
				in_grid = (pos_row != '0);
			end
			mbg_pkg::DIR_SOUTH: begin
				nbr_row = pos_row + RW'(1);
				in_grid = (pos_row != ROW_LAST);
			end
			mbg_pkg::DIR_EAST: begin
				nbr_col = pos_col + CW'(1);
				in_grid = (pos_col != COL_LAST);
			end
			mbg_pkg::DIR_WEST: begin
				nbr_col = pos_col - CW'(1);
				in_grid = (pos_col != '0);
			end
		endcase
		border = (nbr_row == '0) || (nbr_row == ROW_LAST) ||
			(nbr_col == '0) || (nbr_col == COL_LAST);
	end

endmodule

// ===== rtl/core/mbg_pick.sv =====
`timescale 1ns / 1ps

// Picks entry (rnd mod count) of the open-neighbor list, probe order.
module mbg_pick (
	input  logic [3:0]    cand,
	input  logic [15:0]   rnd,
	output logic          any,
	output mbg_pkg::dir_t dir
);

	logic [2:0] n;
	logic [1:0] idx;
	logic [2:0] seen;

	always_comb begin
		n = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
		any = (n != 3'd0);
		case (n)
			3'd2:    idx = {1'b0, rnd[0]};
			3'd3:    idx = mbg_pkg::mod3(rnd);
			3'd4:    idx = rnd[1:0];
			default: idx = 2'd0;
		endcase
		dir  = mbg_pkg::PROBE_DIR[0];
		seen = 3'd0;
		for (int s = 0; s < 4; s++) begin
			if (cand[s] && (seen == {1'b0, idx})) begin
				dir = mbg_pkg::PROBE_DIR[s];
			end
			if (cand[s]) begin
				seen = seen + 3'd1;
			end
		end
	end

endmodule

// ===== rtl/core/maze_backtracker_generator_core.sv =====
`timescale 1ns / 1ps
`include "maze_backtracker_generator_core_assert.svh"

// Depth-first maze carver. Each request transaction (opcode start / step / read) gives exactly
// one response transaction; the core takes one request at a time and raises req_stall until it
// has queued the response. The single-port wall RAM and a sequencer that reuses one neighbor
// unit set the order of work: a step that carves runs four neighbor probes, one read of the
// current cell, the pick with the first wall write, the second wall write and the response; a
// step that backtracks runs the same probes and read, then the pick pops, then the stack read
// and the new cell's wall read; a step that pops the last entry responds straight after the
// pick; a step on an empty stack and an in-grid read do one wall read, then respond; an
// out-of-grid read goes straight to the response; start sweeps every grid cell of the wall RAM
// back to all-closed one cell a cycle, then responds. A held response keeps the core in its
// emit state while rsp_stall keeps the output register full. req_stall drops in the same cycle
// that rsp_valid rises. The same sweep runs after reset, so req_stall first falls when it ends.
// A finished response waits in the output register while the next request is accepted. Walls:
// bit0 north, bit1 east, bit2 south, bit3 west; coordinates on the ports carry the low four bits.
module maze_backtracker_generator_core #(
	parameter int GRID_ROWS = 16,
	parameter int GRID_COLS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  row,
	input  logic [3:0]  col,
	input  logic [15:0] random_value,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  event_res,
	output logic [3:0]  cur_row,
	output logic [3:0]  cur_col,
	output logic [1:0]  direction,
	output logic [3:0]  walls,
	output logic [3:0]  exit_row,
	output logic [3:0]  exit_col,
	output logic [3:0]  start_row,
	output logic [3:0]  start_col
);

	localparam int RW     = $clog2(GRID_ROWS);
	localparam int CW     = $clog2(GRID_COLS);
	localparam int AW     = RW + CW;              // wall RAM address {row, col}
	localparam int CELLS  = GRID_ROWS * GRID_COLS;
	localparam int SW     = $clog2(CELLS);        // trail stack index
	localparam int WDEPTH = GRID_ROWS * (2 ** CW);

	localparam logic [RW-1:0] ROW_LAST  = RW'(GRID_ROWS - 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(GRID_COLS - 1);
	localparam logic [8:0]    ROW_LAST9 = 9'(GRID_ROWS - 1);
	localparam logic [8:0]    COL_LAST9 = 9'(GRID_COLS - 1);
	localparam logic [8:0]    ROWS9     = 9'(GRID_ROWS);
	localparam logic [8:0]    COLS9     = 9'(GRID_COLS);
	localparam logic [SW:0]   CNT_ONE   = (SW + 1)'(1);
	localparam logic [SW:0]   CNT_TWO   = (SW + 1)'(2);
	localparam logic [SW:0]   CNT_FULL  = (SW + 1)'(CELLS);

	typedef enum logic [8:0] {
		S_CLEAR     = 9'b000000001,
		S_IDLE      = 9'b000000010,
		S_WALL_RD   = 9'b000000100,
		S_PROBE     = 9'b000001000,
		S_PROBE_END = 9'b000010000,
		S_PICK      = 9'b000100000,
		S_POP_RD    = 9'b001000000,
		S_CARVE     = 9'b010000000,
		S_EMIT      = 9'b100000000
	} state_t;

	state_t state_q;

	// walk state
	logic [RW-1:0] pos_row_q, exit_row_q, start_row_q, sweep_r_q;
	logic [CW-1:0] pos_col_q, exit_col_q, start_col_q, sweep_c_q;
	logic [SW:0]   stack_count_q;
	logic          clear_emit_q;

	// step working registers
	logic [1:0]          k_q;
	logic [3:0]          cand_q;
	logic [15:0]         rnd_q;
	mbg_pkg::dir_t       dir_q;
	logic                probe_v_s1;
	logic [1:0]          probe_k_s1;
	logic                probe_in_s1;

	// pending result
	mbg_pkg::event_t res_ev_q;
	logic [3:0]      res_row_q, res_col_q;
	mbg_pkg::dir_t   res_dir_q;
	mbg_pkg::wall_t  res_walls_q;

	// response register
	logic            rsp_valid_q;
	mbg_pkg::event_t rsp_ev_q;
	logic [3:0]      rsp_row_q, rsp_col_q, rsp_walls_q;
	logic [3:0]      rsp_exit_row_q, rsp_exit_col_q, rsp_start_row_q, rsp_start_col_q;
	mbg_pkg::dir_t   rsp_dir_q;

	// memories
	mbg_pkg::wall_t wall_mem [WDEPTH];
	logic [AW-1:0]  trail_mem [CELLS];
	logic [AW-1:0]  wall_addr;
	logic           wall_we;
	mbg_pkg::wall_t wall_wdata;
	mbg_pkg::wall_t wall_rd_q;
	logic [SW-1:0]  stk_addr;
	logic           stk_we;
	logic [AW-1:0]  stk_wdata;
	logic [AW-1:0]  stk_rd_q;

	// shared neighbor unit and chooser
	mbg_pkg::dir_t nbr_dir;
	logic [RW-1:0] nbr_row;
	logic [CW-1:0] nbr_col;
	logic          nbr_in_grid;
	logic          nbr_border;
	logic          pick_any;
	mbg_pkg::dir_t pick_dir;

	// request decode
	logic [8:0]    row_ext, col_ext;
	logic [RW-1:0] start_r;
	logic [CW-1:0] start_c;
	logic          rd_in_grid;
	logic          req_take;

	assign nbr_dir = (state_q == S_CARVE) ? dir_q : mbg_pkg::PROBE_DIR[k_q];

	mbg_nbr #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_nbr (
		.pos_row(pos_row_q),
		.pos_col(pos_col_q),
		.dir    (nbr_dir),
		.nbr_row(nbr_row),
		.nbr_col(nbr_col),
		.in_grid(nbr_in_grid),
		.border (nbr_border)
	);

	mbg_pick u_pick (
		.cand(cand_q),
		.rnd (rnd_q),
		.any (pick_any),
		.dir (pick_dir)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;

	// start cell is clamped to the grid; read outside the grid returns closed walls
	always_comb begin
		row_ext    = 9'(row);
		col_ext    = 9'(col);
		start_r    = (row_ext > ROW_LAST9) ? ROW_LAST : RW'(row);
		start_c    = (col_ext > COL_LAST9) ? COL_LAST : CW'(col);
		rd_in_grid = (row_ext < ROWS9) && (col_ext < COLS9);
	end

	// memory port steering
	always_comb begin
		wall_addr  = {pos_row_q, pos_col_q};
		wall_we    = 1'b0;
		wall_wdata = mbg_pkg::MASK_CLOSED;
		stk_addr   = SW'(stack_count_q);
		stk_we     = 1'b0;
		stk_wdata  = {nbr_row, nbr_col};
		unique case (state_q)
			S_CLEAR: begin
				wall_addr = {sweep_r_q, sweep_c_q};
				wall_we   = 1'b1;
			end
			S_IDLE: begin
				if (opcode == mbg_pkg::OP_START) begin
					stk_addr  = '0;
					stk_we    = req_take;
					stk_wdata = {start_r, start_c};
				end else if (opcode != mbg_pkg::OP_STEP) begin
					wall_addr = {RW'(row), CW'(col)};
				end
			end
			S_PROBE: begin
				wall_addr = {nbr_row, nbr_col};
			end
			S_PICK: begin
				if (pick_any) begin
					wall_we    = 1'b1;
					wall_wdata = wall_rd_q & ~mbg_pkg::wall_of(pick_dir);
				end else begin
					stk_addr = SW'(stack_count_q - CNT_TWO);
				end
			end
			S_POP_RD: begin
				wall_addr = stk_rd_q;
			end
			S_CARVE: begin
				wall_addr  = {nbr_row, nbr_col};
				wall_we    = 1'b1;
				wall_wdata = mbg_pkg::MASK_CLOSED & ~mbg_pkg::wall_opposite(dir_q);
				stk_we     = (stack_count_q < CNT_FULL);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wall_we) begin
			wall_mem[wall_addr] <= wall_wdata;
		end
		wall_rd_q <= wall_mem[wall_addr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			trail_mem[stk_addr] <= stk_wdata;
		end
		stk_rd_q <= trail_mem[stk_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			pos_row_q       <= '0;
			pos_col_q       <= '0;
			exit_row_q      <= '0;
			exit_col_q      <= '0;
			start_row_q     <= '0;
			start_col_q     <= '0;
			sweep_r_q       <= '0;
			sweep_c_q       <= '0;
			stack_count_q   <= '0;
			clear_emit_q    <= 1'b0;
			k_q             <= '0;
			cand_q          <= '0;
			rnd_q           <= '0;
			dir_q           <= mbg_pkg::DIR_NORTH;
			probe_v_s1      <= 1'b0;
			probe_k_s1      <= '0;
			probe_in_s1     <= 1'b0;
			res_ev_q        <= mbg_pkg::EV_STARTED;
			res_row_q       <= '0;
			res_col_q       <= '0;
			res_dir_q       <= mbg_pkg::DIR_NORTH;
			res_walls_q     <= mbg_pkg::MASK_CLOSED;
			rsp_valid_q     <= 1'b0;
			rsp_ev_q        <= mbg_pkg::EV_STARTED;
			rsp_row_q       <= '0;
			rsp_col_q       <= '0;
			rsp_dir_q       <= mbg_pkg::DIR_NORTH;
			rsp_walls_q     <= '0;
			rsp_exit_row_q  <= '0;
			rsp_exit_col_q  <= '0;
			rsp_start_row_q <= '0;
			rsp_start_col_q <= '0;
		end else begin
			// probe compare, on the registered RAM read data
			probe_v_s1 <= (state_q == S_PROBE);
			if (probe_v_s1) begin
				cand_q[probe_k_s1] <= probe_in_s1 && (wall_rd_q == mbg_pkg::MASK_CLOSED);
			end
			if ((state_q == S_EMIT) && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					if (sweep_c_q == COL_LAST) begin
						sweep_c_q <= '0;
						if (sweep_r_q == ROW_LAST) begin
							sweep_r_q <= '0;
							state_q   <= clear_emit_q ? S_EMIT : S_IDLE;
						end else begin
							sweep_r_q <= sweep_r_q + RW'(1);
						end
					end else begin
						sweep_c_q <= sweep_c_q + CW'(1);
					end
				end

				S_IDLE: begin
					if (req_take) begin
						res_dir_q <= mbg_pkg::DIR_NORTH;
						rnd_q     <= random_value;
						cand_q    <= '0;
						k_q       <= '0;
						unique case (opcode)
							mbg_pkg::OP_START: begin
								pos_row_q     <= start_r;
								pos_col_q     <= start_c;
								start_row_q   <= start_r;
								start_col_q   <= start_c;
								stack_count_q <= CNT_ONE;
								res_ev_q      <= mbg_pkg::EV_STARTED;
								res_row_q     <= 4'(start_r);
								res_col_q     <= 4'(start_c);
								res_walls_q   <= mbg_pkg::MASK_CLOSED;
								clear_emit_q  <= 1'b1;
								state_q       <= S_CLEAR;
							end
							mbg_pkg::OP_STEP: begin
								if (stack_count_q == '0) begin
									res_ev_q  <= mbg_pkg::EV_FINISHED;
									res_row_q <= 4'(pos_row_q);
									res_col_q <= 4'(pos_col_q);
									state_q   <= S_WALL_RD;
								end else begin
									state_q <= S_PROBE;
								end
							end
							default: begin
								res_ev_q  <= mbg_pkg::EV_READ;
								res_row_q <= row;
								res_col_q <= col;
								if (rd_in_grid) begin
									state_q <= S_WALL_RD;
								end else begin
									res_walls_q <= mbg_pkg::MASK_CLOSED;
									state_q     <= S_EMIT;
								end
							end
						endcase
					end
				end

				S_WALL_RD: begin
					res_walls_q <= wall_rd_q;
					state_q     <= S_EMIT;
				end

				S_PROBE: begin
					probe_k_s1  <= k_q;
					probe_in_s1 <= nbr_in_grid;
					k_q         <= k_q + 2'd1;
					if (k_q == mbg_pkg::PROBE_LAST) begin
						state_q <= S_PROBE_END;
					end
				end

				S_PROBE_END: begin
					// current cell read in flight, last compare lands now
					state_q <= S_PICK;
				end

				S_PICK: begin
					if (pick_any) begin
						dir_q   <= pick_dir;
						state_q <= S_CARVE;
					end else begin
						stack_count_q <= stack_count_q - CNT_ONE;
						if (stack_count_q == CNT_ONE) begin
							res_ev_q    <= mbg_pkg::EV_FINISHED;
							res_row_q   <= 4'(pos_row_q);
							res_col_q   <= 4'(pos_col_q);
							res_walls_q <= wall_rd_q;
							state_q     <= S_EMIT;
						end else begin
							state_q <= S_POP_RD;
						end
					end
				end

				S_POP_RD: begin
					pos_row_q <= stk_rd_q[AW-1:CW];
					pos_col_q <= stk_rd_q[CW-1:0];
					res_ev_q  <= mbg_pkg::EV_BACKTRACKED;
					res_row_q <= 4'(stk_rd_q[AW-1:CW]);
					res_col_q <= 4'(stk_rd_q[CW-1:0]);
					state_q   <= S_WALL_RD;
				end

				S_CARVE: begin
					pos_row_q <= nbr_row;
					pos_col_q <= nbr_col;
					if (nbr_border) begin
						exit_row_q <= nbr_row;
						exit_col_q <= nbr_col;
					end
					if (stack_count_q < CNT_FULL) begin
						stack_count_q <= stack_count_q + CNT_ONE;
					end
					res_ev_q    <= mbg_pkg::EV_CARVED;
					res_row_q   <= 4'(nbr_row);
					res_col_q   <= 4'(nbr_col);
					res_dir_q   <= dir_q;
					res_walls_q <= mbg_pkg::MASK_CLOSED & ~mbg_pkg::wall_opposite(dir_q);
					state_q     <= S_EMIT;
				end

				S_EMIT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_ev_q        <= res_ev_q;
						rsp_row_q       <= res_row_q;
						rsp_col_q       <= res_col_q;
						rsp_dir_q       <= res_dir_q;
						rsp_walls_q     <= res_walls_q;
						rsp_exit_row_q  <= 4'(exit_row_q);
						rsp_exit_col_q  <= 4'(exit_col_q);
						rsp_start_row_q <= 4'(start_row_q);
						rsp_start_col_q <= 4'(start_col_q);
						clear_emit_q    <= 1'b0;
						state_q         <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign event_res = rsp_ev_q;
	assign cur_row   = rsp_row_q;
	assign cur_col   = rsp_col_q;
	assign direction = rsp_dir_q;
	assign walls     = rsp_walls_q;
	assign exit_row  = rsp_exit_row_q;
	assign exit_col  = rsp_exit_col_q;
	assign start_row = rsp_start_row_q;
	assign start_col = rsp_start_col_q;

	`MBG_ASSERT_NXT(a_busy_after_take, req_take, state_q != S_IDLE, "idle right after a request")
	`MBG_ASSERT_IMP(a_stack_bound, 1'b1, stack_count_q <= CNT_FULL, "trail stack overflow")
	`MBG_ASSERT_IMP(a_rsp_from_emit, $rose(rsp_valid_q), $past(state_q == S_EMIT), "response not from emit")
	`MBG_ASSERT_IMP(a_carve_in_grid, state_q == S_CARVE, nbr_in_grid, "carve leaves the grid")

endmodule
